### sv/sis_pkg.sv
// shared types and constants for the stable index sort block
package sis_pkg;

    localparam int KEY_W = 32;
    localparam int TAG_W = 16;

    // one input beat
    typedef struct packed {
        logic signed [KEY_W-1:0] sort_key;
        logic [TAG_W-1:0]        given_tag;
        logic                    final_item;
    } t_in;

    // one result beat
    typedef struct packed {
        logic [TAG_W-1:0]        out_tag;
        logic signed [KEY_W-1:0] out_key;
        logic                    last_result;
        logic                    overflowed;
    } t_out;

    // one stored entry
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } t_entry;

endpackage

### sv/sis_ram.sv
// entry memory: one write port, two registered read ports
module sis_ram #(
    parameter int ADDR_W = 7
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ADDR_W-1:0]     i_waddr,
    input  sis_pkg::t_entry       i_wdata,
    input  logic [ADDR_W-1:0]     i_raddr_a,
    input  logic [ADDR_W-1:0]     i_raddr_b,
    output sis_pkg::t_entry       o_rdata_a,
    output sis_pkg::t_entry       o_rdata_b
);

    sis_pkg::t_entry r_mem [2**ADDR_W];
    sis_pkg::t_entry r_rd_a;
    sis_pkg::t_entry r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

### sv/stable_index_sort_top.sv
// stable index sort top level: load, merge passes and drain sequencer
//
// usage
//   input channel (i_in_valid / o_in_stall) loads one (key, tag) beat per cycle
//   while the block is loading. the beat with final_item set closes the set and
//   starts sorting; o_in_stall stays high until every result has been handed to
//   the output register. beats past MAX_ITEMS are dropped and every result of
//   that set carries overflowed.
//   output channel (o_out_valid / i_out_stall) emits the n stored entries in
//   nondecreasing key order, equal keys in load order, last_result on the final
//   beat. the output register holds its beat while i_out_stall is high.
//   config: i_cfg_we writes tag_source (0: load position, 1: given_tag), sampled
//   per loaded beat.
// sequence, n = entries in the set
//   load one beat per cycle; sort in ceil(log2 n) merge passes, each run set up
//   in S_RUN, then every merged entry read in S_RD and written in S_PICK;
//   drain reads each result in S_DRAIN_RD, waiting there while the output is
//   stalled, and registers it in S_DRAIN_PUT. entry memory reads are registered.
// reset
//   synchronous active low: set empty, overflow cleared, tag_source 0, no beat
//   pending on the output.
module stable_index_sort_top #(
    parameter int MAX_ITEMS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  sis_pkg::t_in    i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output sis_pkg::t_out   o_out
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

    typedef enum logic [2:0] {
        S_LOAD,
        S_RUN,
        S_RD,
        S_PICK,
        S_DRAIN_RD,
        S_DRAIN_PUT
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;    // entries stored in this set
    logic          r_ovf;      // a beat was dropped in this set
    logic          r_tag_src;
    logic [CW-1:0] r_n;        // set size latched on the final beat
    logic [CW-1:0] r_width;    // run width of the current pass
    logic          r_src;      // bank holding the current sorted runs
    logic [CW-1:0] r_lo;
    logic [CW-1:0] r_mid;
    logic [CW-1:0] r_hi;
    logic [CW-1:0] r_a;
    logic [CW-1:0] r_b;
    logic [CW-1:0] r_c;
    logic [CW-1:0] r_k;        // drain position
    logic          r_out_valid;
    sis_pkg::t_out r_out;

    // memory ports
    logic                ram_we;
    logic [AW:0]         ram_waddr;
    sis_pkg::t_entry     ram_wdata;
    logic [AW:0]         ram_raddr_a;
    logic [AW:0]         ram_raddr_b;
    sis_pkg::t_entry     rd_a;
    sis_pkg::t_entry     rd_b;

    // merge and load helpers
    logic          in_acc;
    logic          store_ok;
    logic [CW-1:0] n_count;
    logic [CW:0]   sum_mid;
    logic [CW:0]   sum_hi;
    logic [CW-1:0] n_mid;
    logic [CW-1:0] n_hi;
    logic          take_a;
    logic [CW-1:0] c_next;
    logic          run_done;
    logic          pass_done;
    logic [CW:0]   w2;
    logic          more_pass;
    logic          out_free;
    logic          drain_last;

    assign o_in_stall  = (r_state != S_LOAD);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign store_ok    = (r_count < MAX_C);
    assign n_count     = r_count + CW'(store_ok);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign drain_last  = ((r_k + CW'(1)) == r_n);

    always_comb begin
        // bounds of the run starting at r_lo
        sum_mid = {1'b0, r_lo} + {1'b0, r_width};
        sum_hi  = {1'b0, r_lo} + {r_width, 1'b0};
        n_mid   = (sum_mid > {1'b0, r_n}) ? r_n : sum_mid[CW-1:0];
        n_hi    = (sum_hi > {1'b0, r_n}) ? r_n : sum_hi[CW-1:0];

        // left head wins ties, which keeps load order
        take_a    = (r_a < r_mid) && ((r_b >= r_hi) || !(rd_a.key > rd_b.key));
        c_next    = r_c + CW'(1);
        run_done  = (c_next == r_hi);
        pass_done = run_done && (r_hi == r_n);
        w2        = {r_width, 1'b0};
        more_pass = (w2 < {1'b0, r_n});

        ram_we    = 1'b0;
        ram_waddr = {1'b0, r_count[AW-1:0]};
        ram_wdata.key = i_in.sort_key;
        ram_wdata.tag = r_tag_src ? i_in.given_tag : sis_pkg::TAG_W'(r_count);
        if (r_state == S_LOAD) begin
            ram_we = in_acc && store_ok;
        end else if (r_state == S_PICK) begin
            ram_we    = 1'b1;
            ram_waddr = {~r_src, r_c[AW-1:0]};
            ram_wdata = take_a ? rd_a : rd_b;
        end

        ram_raddr_a = {r_src, r_a[AW-1:0]};
        ram_raddr_b = {r_src, r_b[AW-1:0]};
        if (r_state == S_DRAIN_RD) begin
            ram_raddr_a = {r_src, r_k[AW-1:0]};
        end
    end

    sis_ram #(
        .ADDR_W (AW + 1)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_tag_src   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tag_src <= i_cfg_wdata;
            end
            // output beat taken
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        r_count <= n_count;
                        if (!store_ok) begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in.final_item) begin
                            r_n     <= n_count;
                            r_width <= CW'(1);
                            r_lo    <= '0;
                            r_src   <= 1'b0;
                            r_k     <= '0;
                            // a single entry needs no merging
                            r_state <= (n_count > CW'(1)) ? S_RUN : S_DRAIN_RD;
                        end
                    end
                end
                S_RUN: begin
                    r_mid   <= n_mid;
                    r_hi    <= n_hi;
                    r_a     <= r_lo;
                    r_b     <= n_mid;
                    r_c     <= r_lo;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    if (take_a) begin
                        r_a <= r_a + CW'(1);
                    end else begin
                        r_b <= r_b + CW'(1);
                    end
                    r_c <= c_next;
                    if (pass_done) begin
                        r_width <= w2[CW-1:0];
                        r_src   <= ~r_src;
                        r_lo    <= '0;
                        r_state <= more_pass ? S_RUN : S_DRAIN_RD;
                    end else if (run_done) begin
                        r_lo    <= r_hi;
                        r_state <= S_RUN;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_DRAIN_RD: begin
                    if (out_free) begin
                        r_state <= S_DRAIN_PUT;
                    end
                end
                S_DRAIN_PUT: begin
                    r_out.out_tag     <= rd_a.tag;
                    r_out.out_key     <= rd_a.key;
                    r_out.last_result <= drain_last;
                    r_out.overflowed  <= r_ovf;
                    r_out_valid       <= 1'b1;
                    if (drain_last) begin
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_LOAD;
                    end else begin
                        r_k     <= r_k + CW'(1);
                        r_state <= S_DRAIN_RD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule
